### hdl/itob_pkg.sv
// ============================================================================
// itob_pkg: shared definitions for the integer to radix ASCII converter
// Word size, field widths, character codes and the command that moves
// from the front end through the queue to the digit engine.
// ============================================================================
`default_nettype none

package itob_pkg;

    // Word and field widths
    localparam int WORD_BITS = 32;
    localparam int RADIX_W   = 6;
    localparam int DIGIT_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    localparam int IDX_W     = $clog2(WORD_BITS);
    localparam int BIT_W     = $clog2(WORD_BITS);

    // Command queue depth
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER = 7'd65;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_NULL  = 7'h00;
    localparam logic [CHAR_W-1:0] DEC_TEN  = 7'd10;

    // One classified request on its way to the digit engine
    typedef struct packed {
        logic                 err;
        logic                 neg;
        logic [WORD_BITS-1:0] mag;
    } t_cmd;

    // True when the base is one the converter supports.
    function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
        radix_ok = (r >= RADIX_MIN) && (r <= RADIX_MAX);
    endfunction

    // Map a digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (dx < DEC_TEN) begin
            digit_char = CH_ZERO + dx;
        end else begin
            digit_char = CH_UPPER + dx - DEC_TEN;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/itob_front.sv
// ============================================================================
// itob_front: request intake and classification
// Registers each incoming integer together with its sign, magnitude and
// base check, and hands it to the command queue.
// ============================================================================
`default_nettype none

module itob_front
    import itob_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [WORD_BITS-1:0] s_axis_tdata,   // [31:0] value
    input  wire logic [RADIX_W-1:0]   i_radix,
    output logic                      o_push,
    output t_cmd                      o_cmd,
    input  wire logic                 i_q_ready
);

    logic r_valid, n_valid;
    t_cmd r_cmd,   n_cmd;
    logic accept;
    logic neg;

    // Hold stage is free when empty or when it drains into the queue.
    assign o_push        = r_valid && i_q_ready;
    assign s_axis_tready = !r_valid || i_q_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign neg           = s_axis_tdata[WORD_BITS-1];
    assign o_cmd         = r_cmd;

    // Classify the request: base check, sign and unsigned magnitude.
    always_comb begin
        n_valid = accept || (r_valid && !o_push);
        n_cmd   = r_cmd;
        if (accept) begin
            n_cmd.err = !radix_ok(i_radix);
            n_cmd.neg = neg;
            n_cmd.mag = neg ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

### hdl/itob_fifo.sv
// ============================================================================
// itob_fifo: command queue
// A short first-in first-out queue that decouples the front end from the
// digit engine so that each side can stall on its own.
// ============================================================================
`default_nettype none

module itob_fifo
    import itob_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt,  n_cnt;
    logic              do_push, do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wptr = do_push ? QPTR_W'(r_wptr + 1'b1) : r_wptr;
        n_rptr = do_pop  ? QPTR_W'(r_rptr + 1'b1) : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### hdl/itob_back.sv
// ============================================================================
// itob_back: digit engine and character emitter
// Divides the magnitude by the base one quotient bit per cycle, stacks the
// remainders, then emits sign and digits most significant first through
// an output register; a bad base yields a single error character instead.
// ============================================================================
`default_nettype none

module itob_back
    import itob_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [RADIX_W-1:0] i_radix,
    input  wire logic               i_q_valid,
    input  wire t_cmd               i_cmd,
    output logic                    o_pop,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic                    m_axis_tlast,
    output logic                    m_axis_tuser    // [0] base_error
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [WORD_BITS-1:0] r_mag,   n_mag;
    logic [DIGIT_W-1:0]   r_rem,   n_rem;
    logic [BIT_W-1:0]     r_bit,   n_bit;
    logic [CNT_W-1:0]     r_ndig,  n_ndig;
    logic                 r_neg,   n_neg;
    logic [DIGIT_W-1:0]   r_stack [WORD_BITS];

    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char,  n_out_char;
    logic                 r_out_last,  n_out_last;
    logic                 r_out_err,   n_out_err;

    logic                 out_free;
    logic [DIGIT_W:0]     rem_sh;
    logic                 q_bit;
    logic [DIGIT_W:0]     rem_sub;
    logic [DIGIT_W-1:0]   rem_nx;
    logic [WORD_BITS-1:0] quo_nx;
    logic [CNT_W-1:0]     top_cnt;
    logic [IDX_W-1:0]     top_idx;
    logic                 push_dig;

    assign out_free = !r_out_valid || m_axis_tready;

    // One restoring division step: shift in the next magnitude bit.
    assign rem_sh  = {r_rem, r_mag[WORD_BITS-1]};
    assign q_bit   = (rem_sh >= {1'b0, i_radix});
    assign rem_sub = q_bit ? (rem_sh - {1'b0, i_radix}) : rem_sh;
    assign rem_nx  = rem_sub[DIGIT_W-1:0];
    assign quo_nx  = {r_mag[WORD_BITS-2:0], q_bit};

    // Top of the digit stack.
    assign top_cnt = r_ndig - 1'b1;
    assign top_idx = top_cnt[IDX_W-1:0];

    assign push_dig = (r_state == S_DIV) && (r_bit == BIT_W'(WORD_BITS - 1));
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    // Sequencer: division loop, then sign and digit emission, or an error character for a bad base.
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_ndig      = r_ndig;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_mag   = i_cmd.mag;
                    n_neg   = i_cmd.neg;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_ndig  = '0;
                    n_state = i_cmd.err ? S_ERR : S_DIV;
                end
            end
            S_DIV: begin
                n_mag = quo_nx;
                if (push_dig) begin
                    n_rem  = '0;
                    n_bit  = '0;
                    n_ndig = r_ndig + 1'b1;
                    if (quo_nx == '0) begin
                        n_state = S_SIGN;
                    end
                end else begin
                    n_rem = rem_nx;
                    n_bit = r_bit + 1'b1;
                end
            end
            S_SIGN: begin
                if (!r_neg) begin
                    n_state = S_EMIT;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_MINUS;
                    n_out_last  = 1'b0;
                    n_out_err   = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(r_stack[top_idx]);
                    n_out_last  = (top_cnt == '0);
                    n_out_err   = 1'b0;
                    n_ndig      = top_cnt;
                    if (top_cnt == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_NULL;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_ndig     <= n_ndig;
        r_neg      <= n_neg;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    // Digit stack: the final remainder of each division is pushed.
    always_ff @(posedge i_clk) begin
        if (push_dig) begin
            r_stack[r_ndig[IDX_W-1:0]] <= rem_nx;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_char};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

endmodule

`default_nettype wire

### hdl/integer_to_radix_ascii_unit.sv
// Flow: the front stage registers each integer, the queue buffers it, the
// bit-serial divider produces each digit, then the sign step and the output
// register emit one character per cycle while the receiver is ready. The front
// stage and queue take new integers while the engine works on the current one.
// Reset: synchronous active low; clears the queue, engine and output valid,
// and sets the base to 10.
// ============================================================================
// integer_to_radix_ascii_unit: signed integer to ASCII string in base 2..36
// Converts each incoming integer to characters, most significant first,
// with a leading minus sign for negatives and an error result for a bad base.
// ============================================================================
`default_nettype none

module integer_to_radix_ascii_unit
    import itob_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [RADIX_W-1:0]   i_cfg_wdata,    // radix
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [WORD_BITS-1:0] s_axis_tdata,   // [31:0] value
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic                      m_axis_tlast,   // last_char
    output logic                      m_axis_tuser    // [0] base_error
);

    logic [RADIX_W-1:0] r_radix;
    logic               push, q_ready, q_valid, pop;
    t_cmd               front_cmd, q_cmd;

    // Base register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    itob_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_radix       (r_radix),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_q_ready     (q_ready)
    );

    itob_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    itob_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_radix       (r_radix),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the integer to radix ASCII converter
// A table of directed requests covers the base extremes, zero, the most
// negative value and bad bases. Random requests follow in four handshake
// phases. Every character on the output stream is checked against the typed
// spelling of a table row or a local model of the conversion.
// ============================================================================

module tb_top;
    import itob_pkg::*;

    localparam int TEXT_CHARS    = 33;
    localparam int TEXT_W        = TEXT_CHARS * 8;
    localparam int NUM_ROWS      = 25;
    localparam int BLOCKS        = 4;
    localparam int BLOCK_ITEMS   = 20;
    localparam int REPORT_MAX    = 10;
    localparam int STALL_LIMIT   = 10000;
    localparam int TAIL_CYCLES   = 64;

    // One character of a spelled number
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              err;
    } t_char;

    // One row of the directed table; text holds the spelling when it is typed in
    typedef struct packed {
        logic [RADIX_W-1:0]   radix;
        logic [WORD_BITS-1:0] value;
        logic                 typed;
        logic                 err;
        logic [TEXT_W-1:0]    text;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [RADIX_W-1:0]   cfg_radix = '0;
    logic                 req_valid = 1'b0;
    logic [WORD_BITS-1:0] req_value = '0;
    logic                 rx_ready = 1'b0;
    wire                  s_axis_tready;
    wire                  m_axis_tvalid;
    wire  [7:0]           m_axis_tdata;
    wire                  m_axis_tlast;
    wire                  m_axis_tuser;

    t_char                pending_chars[$];
    t_char                oldest_char;
    t_row                 directed_rows[NUM_ROWS];
    logic [RADIX_W-1:0]   active_radix = RADIX_RESET;
    int                   bad_chars = 0;
    int                   quiet_cycles = 0;
    int                   send_idle_pct = 0;
    int                   rx_stall_pct = 0;

    integer_to_radix_ascii_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_radix),
        .s_axis_tvalid (req_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (req_value),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (rx_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Spell one integer in the given base and queue the characters.
    function automatic void predict_spelling(input logic [RADIX_W-1:0] base,
                                             input logic [WORD_BITS-1:0] word);
        logic [WORD_BITS-1:0] mag;
        logic [WORD_BITS-1:0] base_w;
        logic [WORD_BITS-1:0] dig;
        logic [CHAR_W-1:0]    digits[WORD_BITS];
        logic                 neg;
        int                   nd;
        if (base < RADIX_MIN || base > RADIX_MAX) begin
            pending_chars.push_back(t_char'{CH_NULL, 1'b1, 1'b1});
            return;
        end
        base_w = {{(WORD_BITS - RADIX_W){1'b0}}, base};
        neg = word[WORD_BITS-1];
        mag = neg ? (~word + 1'b1) : word;
        nd = 0;
        // Least significant digit first; zero still yields one digit
        do begin
            dig = mag % base_w;
            mag = mag / base_w;
            digits[nd] = (dig < 10) ? CH_ZERO + CHAR_W'(dig) : CH_UPPER + CHAR_W'(dig - 10);
            nd++;
        end while (mag != 0);
        if (neg) begin
            pending_chars.push_back(t_char'{CH_MINUS, 1'b0, 1'b0});
        end
        for (int i = nd - 1; i >= 0; i--) begin
            pending_chars.push_back(t_char'{digits[i], (i == 0), 1'b0});
        end
    endfunction

    // Queue the spelling that a table row gives explicitly.
    function automatic void queue_typed_text(input t_row row);
        logic [7:0] ch;
        int         total;
        int         seen;
        if (row.err) begin
            pending_chars.push_back(t_char'{CH_NULL, 1'b1, 1'b1});
            return;
        end
        total = 0;
        for (int i = 0; i < TEXT_CHARS; i++) begin
            if (row.text[i*8 +: 8] != 8'd0) total++;
        end
        seen = 0;
        for (int i = TEXT_CHARS - 1; i >= 0; i--) begin
            ch = row.text[i*8 +: 8];
            if (ch != 8'd0) begin
                seen++;
                pending_chars.push_back(t_char'{ch[CHAR_W-1:0], (seen == total), 1'b0});
            end
        end
    endfunction

    function automatic t_row mk_row(input logic [RADIX_W-1:0] r,
                                    input logic [WORD_BITS-1:0] v,
                                    input logic typed, input logic err,
                                    input logic [TEXT_W-1:0] txt);
        mk_row = t_row'{r, v, typed, err, txt};
    endfunction

    // Random value: full words, small numbers, extremes, base powers and shifted words.
    function automatic logic [WORD_BITS-1:0] pick_value(input logic [RADIX_W-1:0] base);
        logic [63:0]          p;
        logic [WORD_BITS-1:0] v;
        case ($urandom_range(0, 9))
            5: v = $urandom_range(0, 99);
            6: v = -$urandom_range(1, 99);
            7: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            8: begin
                if (base >= RADIX_MIN && base <= RADIX_MAX) begin
                    p = 64'd1;
                    repeat ($urandom_range(1, 31)) begin
                        if (p * base <= 64'hFFFF_FFFF) p = p * base;
                    end
                    v = p[WORD_BITS-1:0] - $urandom_range(0, 1);
                    if ($urandom_range(0, 1) == 1) v = -v;
                end else begin
                    v = $urandom;
                end
            end
            9: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Base for one random block: fixed extremes first, then mostly valid bases.
    function automatic logic [RADIX_W-1:0] pick_radix(input int blk);
        case (blk)
            0: return RADIX_MIN;
            1: return RADIX_MAX;
            2: return 6'd0;
            3: return 6'd63;
            default: begin
                if ($urandom_range(0, 99) < 15) begin
                    if ($urandom_range(0, 1) == 1) return RADIX_W'($urandom_range(0, 1));
                    return RADIX_W'($urandom_range(37, 63));
                end
                return RADIX_W'($urandom_range(2, 36));
            end
        endcase
    endfunction

    // Wait until every queued character has come back.
    task automatic wait_drained();
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        cfg_we    <= 1'b1;
        cfg_radix <= r;
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        active_radix  = r;
    endtask

    // Offer one request, hold it until accepted, then queue its spelling.
    // The valid stays high on return so a following request can reuse it.
    task automatic send_value(input logic [WORD_BITS-1:0] v, input logic typed,
                              input t_row row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_value <= v;
        do @(posedge i_clk); while (!(req_valid && s_axis_tready));
        if (typed) queue_typed_text(row);
        else predict_spelling(active_radix, v);
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        rx_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Output checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && rx_ready) begin
            if (pending_chars.size() == 0) begin
                bad_chars++;
                if (bad_chars <= REPORT_MAX) begin
                    $display("unexpected character: code %h last %b err %b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end else begin
                oldest_char = pending_chars.pop_front();
                if (m_axis_tdata != {1'b0, oldest_char.code} ||
                    m_axis_tlast != oldest_char.last ||
                    m_axis_tuser != oldest_char.err) begin
                    bad_chars++;
                    if (bad_chars <= REPORT_MAX) begin
                        $display({"character mismatch: expected code %h last %b err %b, ",
                                  "got %h %b %b"},
                                 {1'b0, oldest_char.code}, oldest_char.last, oldest_char.err,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && s_axis_tready) || (m_axis_tvalid && rx_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Directed table
    initial begin
        directed_rows[0]  = mk_row(6'd10, 32'd0,          1'b1, 1'b0, "0");
        directed_rows[1]  = mk_row(6'd10, 32'h7FFF_FFFF,  1'b1, 1'b0, "2147483647");
        directed_rows[2]  = mk_row(6'd10, 32'h8000_0000,  1'b1, 1'b0, "-2147483648");
        directed_rows[3]  = mk_row(6'd10, 32'hFFFF_FFFF,  1'b1, 1'b0, "-1");
        directed_rows[4]  = mk_row(6'd10, 32'd9,          1'b1, 1'b0, "9");
        directed_rows[5]  = mk_row(6'd2,  32'h8000_0000,  1'b1, 1'b0,
                                   {"-1", "00000000", "00000000", "00000000", "0000000"});
        directed_rows[6]  = mk_row(6'd2,  32'h7FFF_FFFF,  1'b1, 1'b0,
                                   {"11111111", "11111111", "11111111", "1111111"});
        directed_rows[7]  = mk_row(6'd2,  32'd0,          1'b1, 1'b0, "0");
        directed_rows[8]  = mk_row(6'd2,  32'hFFFF_FFFF,  1'b1, 1'b0, "-1");
        directed_rows[9]  = mk_row(6'd3,  32'd8,          1'b1, 1'b0, "22");
        directed_rows[10] = mk_row(6'd8,  32'hFFFF_FFF8,  1'b1, 1'b0, "-10");
        directed_rows[11] = mk_row(6'd11, 32'd10,         1'b1, 1'b0, "A");
        directed_rows[12] = mk_row(6'd16, 32'd255,        1'b1, 1'b0, "FF");
        directed_rows[13] = mk_row(6'd16, 32'hDEAD_BEEF,  1'b0, 1'b0, '0);
        directed_rows[14] = mk_row(6'd35, 32'd34,         1'b1, 1'b0, "Y");
        directed_rows[15] = mk_row(6'd36, 32'd35,         1'b1, 1'b0, "Z");
        directed_rows[16] = mk_row(6'd36, 32'd36,         1'b1, 1'b0, "10");
        directed_rows[17] = mk_row(6'd36, 32'h8000_0000,  1'b0, 1'b0, '0);
        directed_rows[18] = mk_row(6'd36, 32'h7FFF_FFFF,  1'b0, 1'b0, '0);
        directed_rows[19] = mk_row(6'd0,  32'd5,          1'b1, 1'b1, '0);
        directed_rows[20] = mk_row(6'd1,  32'd0,          1'b1, 1'b1, '0);
        directed_rows[21] = mk_row(6'd37, 32'hFFFF_FFFF,  1'b1, 1'b1, '0);
        directed_rows[22] = mk_row(6'd63, 32'd123,        1'b1, 1'b1, '0);
        directed_rows[23] = mk_row(6'd7,  32'd12345,      1'b0, 1'b0, '0);
        directed_rows[24] = mk_row(6'd10, 32'hFFFF_CFC7,  1'b1, 1'b0, "-12345");
    end

    // Main sequence
    initial begin
        t_row no_row;
        no_row = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part; the first row runs on the base left by reset
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (directed_rows[r].radix != active_radix) begin
                req_valid <= 1'b0;
                wait_drained();
                write_radix(directed_rows[r].radix);
            end
            send_value(directed_rows[r].value, directed_rows[r].typed, directed_rows[r]);
        end

        // Random part in four handshake phases, each with several bases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin send_idle_pct = 77; rx_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct = 77; end
                default: begin send_idle_pct = 9; rx_stall_pct = 9; end
            endcase
            for (int b = 0; b < BLOCKS; b++) begin
                req_valid <= 1'b0;
                wait_drained();
                write_radix(pick_radix(ph * BLOCKS + b));
                for (int n = 0; n < BLOCK_ITEMS; n++) begin
                    send_value(pick_value(active_radix), 1'b0, no_row);
                end
            end
        end

        // Let everything come back, then watch for stray characters
        req_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_chars == 0 && pending_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
hdl/itob_pkg.sv
hdl/itob_front.sv
hdl/itob_fifo.sv
hdl/itob_back.sv
hdl/integer_to_radix_ascii_unit.sv
tb/tb_top.sv
